/* hdl/tlt_pkg.sv */
// Shared constants, lane types and the arctangent table of the tilt block.
package tlt_pkg;

  // Calibration samples that are averaged into one set of offsets.
  localparam int CalSamples = 100;
  localparam int CalCntW    = 8;
  localparam int SumW       = 24;

  // Averaging by reciprocal multiplication: floor(n / CalSamples) equals
  // (n * CalRecip) >> CalRecipShift for every sum magnitude that can occur.
  localparam int          CalRecipShift = 29;
  localparam logic [22:0] CalRecip      =
    23'((longint'(1) << CalRecipShift) / CalSamples + 1);

  // Square root chain: one cell for each bit of the root.
  localparam int SqrtSteps  = 30;
  // CORDIC chain: one cell for each micro-rotation.
  localparam int CordicSteps = 24;

  // Largest angle magnitude in 1/128 degree.
  localparam logic [13:0] AngleMax = 14'd11520;

  // Tags that tell the two angles of one sample apart.
  localparam logic TagRoll  = 1'b0;
  localparam logic TagPitch = 1'b1;

  // One beat in the square root chain.
  typedef struct packed {
    logic                valid;
    logic                tag;
    logic [31:0]         s;
    logic [30:0]         rem;
    logic [29:0]         root;
    logic signed [16:0]  num;
  } sq_lane_t;

  // One beat in the CORDIC chain.
  typedef struct packed {
    logic                valid;
    logic                tag;
    logic                zero;
    logic signed [32:0]  x;
    logic signed [32:0]  y;
    logic signed [31:0]  z;
  } cd_lane_t;

  // Status of the calibration unit.
  typedef struct packed {
    logic busy;
    logic calibrated;
  } cal_stat_t;

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:    val = 32'sd47185920;
      5'd1:    val = 32'sd27855475;
      5'd2:    val = 32'sd14718068;
      5'd3:    val = 32'sd7471121;
      5'd4:    val = 32'sd3750058;
      5'd5:    val = 32'sd1876857;
      5'd6:    val = 32'sd938658;
      5'd7:    val = 32'sd469357;
      5'd8:    val = 32'sd234682;
      5'd9:    val = 32'sd117342;
      5'd10:   val = 32'sd58671;
      5'd11:   val = 32'sd29335;
      5'd12:   val = 32'sd14668;
      5'd13:   val = 32'sd7334;
      5'd14:   val = 32'sd3667;
      5'd15:   val = 32'sd1833;
      5'd16:   val = 32'sd917;
      5'd17:   val = 32'sd458;
      5'd18:   val = 32'sd229;
      5'd19:   val = 32'sd115;
      5'd20:   val = 32'sd57;
      5'd21:   val = 32'sd29;
      5'd22:   val = 32'sd14;
      5'd23:   val = 32'sd7;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

/* hdl/tlt_sqrt_cell.sv */
// One cell of the square root chain: settles one bit of the root per beat.
module tlt_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlt_pkg::sq_lane_t  lane_i,
  output tlt_pkg::sq_lane_t  lane_o
);

  logic [32:0]        trial_rem;
  logic [32:0]        trial_sub;
  logic               fits;
  tlt_pkg::sq_lane_t  lane_d;
  tlt_pkg::sq_lane_t  lane_q;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    trial_rem = {lane_i.rem, lane_i.s[31:30]};
    trial_sub = {1'b0, lane_i.root, 2'b01};
    fits      = (trial_rem >= trial_sub);
    lane_d        = lane_i;
    lane_d.s      = {lane_i.s[29:0], 2'b00};
    lane_d.rem    = fits ? 31'(trial_rem - trial_sub) : trial_rem[30:0];
    lane_d.root   = {lane_i.root[28:0], fits};
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* hdl/tlt_cordic_cell.sv */
// One cell of the CORDIC chain: one vectoring micro-rotation per beat.
module tlt_cordic_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         iter_i,
  input  tlt_pkg::cd_lane_t  lane_i,
  output tlt_pkg::cd_lane_t  lane_o
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [31:0] ang;
  tlt_pkg::cd_lane_t  lane_d;
  tlt_pkg::cd_lane_t  lane_q;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    dx     = lane_i.y >>> iter_i;
    dy     = lane_i.x >>> iter_i;
    ang    = tlt_pkg::atan_entry(iter_i);
    lane_d = lane_i;
    if (!lane_i.y[32]) begin
      lane_d.x = lane_i.x + dx;
      lane_d.y = lane_i.y - dy;
      lane_d.z = lane_i.z + ang;
    end else begin
      lane_d.x = lane_i.x - dx;
      lane_d.y = lane_i.y + dy;
      lane_d.z = lane_i.z - ang;
    end
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* hdl/tlt_cal.sv */
// Bias calibration: per-axis sums, reciprocal-multiply averaging and the offset registers.
module tlt_cal (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_i,
  input  logic signed [15:0]  samp_i [6],
  input  logic [1:0]          accel_range_i,
  output logic signed [15:0]  offset_o [6],
  output tlt_pkg::cal_stat_t  stat_o
);

  logic signed [tlt_pkg::SumW-1:0]    sums_q [6];
  logic signed [tlt_pkg::SumW-1:0]    sum_nx [6];
  logic [tlt_pkg::SumW-1:0]           mag_q [6];
  logic                               neg_q [6];
  logic signed [15:0]                 off_q [6];
  logic [46:0]                        prod [6];
  logic [15:0]                        quot [6];
  logic [15:0]                        off_nx [6];
  logic [tlt_pkg::CalCntW-1:0]        cnt_q;
  logic                               busy_q;
  logic                               cal_q;
  logic                               last_sample;
  logic [15:0]                        one_g;

  assign last_sample = (cnt_q == tlt_pkg::CalCntW'(tlt_pkg::CalSamples - 1));
  assign one_g       = 16'(16'd16384 >> accel_range_i);

  // Next sums, the quotient of each magnitude by the sample count, and the offsets.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sum_nx[k] = sums_q[k] + {{(tlt_pkg::SumW-16){samp_i[k][15]}}, samp_i[k]};
      prod[k]   = 47'(mag_q[k]) * 47'(tlt_pkg::CalRecip);
      quot[k]   = prod[k][tlt_pkg::CalRecipShift+15:tlt_pkg::CalRecipShift];
      off_nx[k] = neg_q[k] ? 16'(16'd0 - quot[k]) : quot[k];
    end
    off_nx[2] = 16'(off_nx[2] - one_g);
  end

  // Accumulate samples, then load the averaged offsets in the cycle after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        sums_q[k] <= '0;
        mag_q[k]  <= '0;
        neg_q[k]  <= 1'b0;
        off_q[k]  <= '0;
      end
      cnt_q  <= '0;
      busy_q <= 1'b0;
      cal_q  <= 1'b0;
    end else if (busy_q) begin
      for (int k = 0; k < 6; k++) begin
        off_q[k] <= off_nx[k];
      end
      busy_q <= 1'b0;
      cal_q  <= 1'b1;
    end else if (sample_i) begin
      if (last_sample) begin
        for (int k = 0; k < 6; k++) begin
          mag_q[k]  <= sum_nx[k][tlt_pkg::SumW-1] ? tlt_pkg::SumW'(-sum_nx[k])
                                                  : sum_nx[k];
          neg_q[k]  <= sum_nx[k][tlt_pkg::SumW-1];
          sums_q[k] <= '0;
        end
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else begin
        for (int k = 0; k < 6; k++) begin
          sums_q[k] <= sum_nx[k];
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign offset_o          = off_q;
  assign stat_o.busy       = busy_q;
  assign stat_o.calibrated = cal_q;

endmodule

/* hdl/accel_tilt_with_bias_calibration.sv */
// Datapath: an accepted measurement beat runs through the square root chain (30 cells)
// and then the CORDIC chain (24 cells) before its result appears.
// Flow: one item at a time; a new beat is accepted only when the sequencer is idle and
// no result is held, and the beat that completes a calibration also waits for averaging.
// Reset (rst_ni low, asynchronous) clears sums, count, offsets, accel_range and
// the calibrated flag at once; no clearing pass is needed.
module accel_tilt_with_bias_calibration (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic signed [15:0]  gyro_x_i,
  input  logic signed [15:0]  gyro_y_i,
  input  logic signed [15:0]  gyro_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  roll_o,
  output logic signed [14:0]  pitch_o,
  output logic signed [15:0]  rate_x_o,
  output logic signed [15:0]  rate_y_o,
  output logic signed [15:0]  rate_z_o,
  output logic                offsets_ready_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StRoll   = 3'd2;
  localparam logic [2:0] StPitch  = 3'd3;
  localparam logic [2:0] StWait   = 3'd4;
  localparam logic [2:0] StCal    = 3'd5;

  logic [2:0]                  state_q;
  logic [2:0]                  state_d;
  logic [1:0]                  range_q;
  logic signed [15:0]          samp [6];
  logic signed [15:0]          offset [6];
  tlt_pkg::cal_stat_t          cal_stat;
  logic                        in_fire;
  logic signed [15:0]          corr_q [3];
  logic signed [15:0]          rate_q [3];
  logic signed [31:0]          prod [3];
  logic [30:0]                 sq_q [3];
  logic                        flag_q;
  tlt_pkg::sq_lane_t           feed_d;
  tlt_pkg::sq_lane_t           sq_chain [tlt_pkg::SqrtSteps+1];
  tlt_pkg::cd_lane_t           cd_chain [tlt_pkg::CordicSteps+1];
  tlt_pkg::sq_lane_t           sq_last;
  logic signed [31:0]          z_fin;
  logic [31:0]                 z_mag;
  logic [31:0]                 round_sum;
  logic [18:0]                 q_full;
  logic [13:0]                 q_clamp;
  logic signed [14:0]          angle;
  logic                        fin_valid_q;
  logic                        fin_tag_q;
  logic signed [14:0]          fin_angle_q;
  logic signed [14:0]          roll_q;
  logic signed [14:0]          pitch_q;
  logic                        out_valid_q;

  assign samp[0] = accel_x_i;
  assign samp[1] = accel_y_i;
  assign samp[2] = accel_z_i;
  assign samp[3] = gyro_x_i;
  assign samp[4] = gyro_y_i;
  assign samp[5] = gyro_z_i;

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // Range register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 2'd0;
    end else if (cfg_we_i) begin
      range_q <= cfg_data_i;
    end
  end

  // Calibration unit.
  tlt_cal u_cal (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (in_fire && !kind_i),
    .samp_i       (samp),
    .accel_range_i(range_q),
    .offset_o     (offset),
    .stat_o       (cal_stat)
  );

  // Sequencer over one beat.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_fire) state_d = kind_i ? StSquare : StCal;
      StSquare: state_d = StRoll;
      StRoll:   state_d = StPitch;
      StPitch:  state_d = StWait;
      StWait:   if (fin_valid_q && (fin_tag_q == tlt_pkg::TagPitch)) state_d = StIdle;
      StCal:    if (!cal_stat.busy) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Offset correction on acceptance, then the squares.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = corr_q[k] * corr_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i) begin
      for (int k = 0; k < 3; k++) begin
        corr_q[k] <= 16'(samp[k] - offset[k]);
        rate_q[k] <= 16'(samp[k+3] - offset[k+3]);
      end
      flag_q <= cal_stat.calibrated;
    end
    if (state_q == StSquare) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= prod[k][30:0];
      end
    end
  end

  // Feed roll, then pitch, into the square root chain.
  always_comb begin
    feed_d = '0;
    if (state_q == StRoll) begin
      feed_d.valid = 1'b1;
      feed_d.tag   = tlt_pkg::TagRoll;
      feed_d.s     = 32'(sq_q[0]) + 32'(sq_q[2]);
      feed_d.num   = 17'(corr_q[1]);
    end else if (state_q == StPitch) begin
      feed_d.valid = 1'b1;
      feed_d.tag   = tlt_pkg::TagPitch;
      feed_d.s     = 32'(sq_q[1]) + 32'(sq_q[2]);
      feed_d.num   = 17'(17'sd0 - 17'(corr_q[0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_chain[0] <= '0;
    end else begin
      sq_chain[0] <= feed_d;
    end
  end

  // Square root chain.
  for (genvar g = 0; g < tlt_pkg::SqrtSteps; g++) begin : g_sqrt
    tlt_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .lane_i(sq_chain[g]),
      .lane_o(sq_chain[g+1])
    );
  end

  // Root and scaled numerator start the rotation.
  assign sq_last = sq_chain[tlt_pkg::SqrtSteps];
  always_comb begin
    cd_chain[0].valid = sq_last.valid;
    cd_chain[0].tag   = sq_last.tag;
    cd_chain[0].zero  = (sq_last.root == '0) && (sq_last.num == '0);
    cd_chain[0].x     = {3'b000, sq_last.root};
    cd_chain[0].y     = {{16{sq_last.num[16]}}, sq_last.num} <<< 14;
    cd_chain[0].z     = '0;
  end

  // CORDIC chain.
  for (genvar g = 0; g < tlt_pkg::CordicSteps; g++) begin : g_cordic
    tlt_cordic_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .iter_i(5'(g)),
      .lane_i(cd_chain[g]),
      .lane_o(cd_chain[g+1])
    );
  end

  // Round the angle sum to 1/128 degree and clamp it.
  always_comb begin
    z_fin     = cd_chain[tlt_pkg::CordicSteps].z;
    z_mag     = z_fin[31] ? 32'(-z_fin) : 32'(z_fin);
    round_sum = z_mag + 32'd4096;
    q_full    = round_sum[31:13];
    q_clamp   = (q_full > 19'(tlt_pkg::AngleMax)) ? tlt_pkg::AngleMax : q_full[13:0];
    if (cd_chain[tlt_pkg::CordicSteps].zero) begin
      angle = '0;
    end else if (z_fin[31]) begin
      angle = 15'(15'sd0 - $signed({1'b0, q_clamp}));
    end else begin
      angle = $signed({1'b0, q_clamp});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      fin_tag_q   <= tlt_pkg::TagRoll;
      fin_angle_q <= '0;
    end else begin
      fin_valid_q <= cd_chain[tlt_pkg::CordicSteps].valid;
      fin_tag_q   <= cd_chain[tlt_pkg::CordicSteps].tag;
      fin_angle_q <= angle;
    end
  end

  // Output register: filled when the pitch beat arrives, freed on the out beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
    end else begin
      if (fin_valid_q && (fin_tag_q == tlt_pkg::TagRoll)) begin
        roll_q <= fin_angle_q;
      end
      if (fin_valid_q && (fin_tag_q == tlt_pkg::TagPitch)) begin
        pitch_q     <= fin_angle_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign roll_o          = roll_q;
  assign pitch_o         = pitch_q;
  assign rate_x_o        = rate_q[0];
  assign rate_y_o        = rate_q[1];
  assign rate_z_o        = rate_q[2];
  assign offsets_ready_o = flag_q;

  // The calibration divide only runs while the sequencer waits for it.
  a_cal_busy_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_stat.busy |-> (state_q == StCal))
    else $error("calibration divide outside its wait state");

  // A pitch result only arrives while the sequencer waits for it.
  a_pitch_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && (fin_tag_q == tlt_pkg::TagPitch)) |-> (state_q == StWait))
    else $error("pitch result outside the wait state");

  // A held result blocks new input beats.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o)
    else $error("input accepted while a result is held");

  // An accepted measurement beat starts the square stage next.
  a_measure_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i) |=> (state_q == StSquare))
    else $error("measurement beat did not start the datapath");

endmodule

/* tb/tilt_checker.sv */
// Checker for the tilt block: predicts each measurement result and compares it with the output.
module tilt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               kind_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [14:0] roll_i,
  input  logic signed [14:0] pitch_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic               offsets_ready_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               offsets_ready;
  } tilt_result_t;

  tilt_result_t tilt_results_q[$];

  // Model copy of the block state.
  logic [1:0]         range_m;
  int                 acc_sum_m[3];
  int                 gyr_sum_m[3];
  int                 cal_count_m;
  logic signed [15:0] acc_off_m[3];
  logic signed [15:0] gyr_off_m[3];
  logic               calibrated_m;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Angle of num over the hypotenuse of a and b, in 1/128 degree.
  function automatic logic signed [14:0] tilt_angle(input longint num, input longint a,
                                                    input longint b);
    longint x, y, z, dx, dy, q;
    x = longint'(int_sqrt(longint'(a * a + b * b) << 28));
    y = num * 16384;
    z = 0;
    if (x == 0 && y == 0) return '0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(tlt_pkg::atan_entry(5'(i)));
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(tlt_pkg::atan_entry(5'(i)));
      end
    end
    if (z >= 0) q = (z + 4096) >>> 13;
    else q = -((-z + 4096) >>> 13);
    if (q > 11520) q = 11520;
    if (q < -11520) q = -11520;
    return 15'(q);
  endfunction

  assign pending_o = tilt_results_q.size();

  // Prediction on input beats and config writes, comparison on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] acc[3];
    logic signed [15:0] gyr[3];
    logic signed [15:0] cx, cy, cz;
    int avg;
    tilt_result_t r, e;
    if (!rst_ni) begin
      range_m      <= '0;
      cal_count_m  <= 0;
      calibrated_m <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_sum_m[i] <= 0;
        gyr_sum_m[i] <= 0;
        acc_off_m[i] <= '0;
        gyr_off_m[i] <= '0;
      end
      fail_count_o <= 0;
      tilt_results_q.delete();
    end else begin
      if (cfg_we_i) range_m <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        acc = '{accel_x_i, accel_y_i, accel_z_i};
        gyr = '{gyro_x_i, gyro_y_i, gyro_z_i};
        if (kind_i == 1'b0) begin
          if (cal_count_m + 1 >= tlt_pkg::CalSamples) begin
            for (int i = 0; i < 3; i++) begin
              avg = (acc_sum_m[i] + int'(acc[i])) / tlt_pkg::CalSamples;
              // The z axis carries one g at rest; take it out of the offset.
              if (i == 2) avg = avg - (16384 >> range_m);
              acc_off_m[i] <= 16'(avg);
              gyr_off_m[i] <= 16'((gyr_sum_m[i] + int'(gyr[i])) / tlt_pkg::CalSamples);
              acc_sum_m[i] <= 0;
              gyr_sum_m[i] <= 0;
            end
            cal_count_m  <= 0;
            calibrated_m <= 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              acc_sum_m[i] <= acc_sum_m[i] + int'(acc[i]);
              gyr_sum_m[i] <= gyr_sum_m[i] + int'(gyr[i]);
            end
            cal_count_m <= cal_count_m + 1;
          end
        end else begin
          cx = acc[0] - acc_off_m[0];
          cy = acc[1] - acc_off_m[1];
          cz = acc[2] - acc_off_m[2];
          e.roll          = tilt_angle(cy, cx, cz);
          e.pitch         = tilt_angle(-longint'(cx), cy, cz);
          e.rate_x        = gyr[0] - gyr_off_m[0];
          e.rate_y        = gyr[1] - gyr_off_m[1];
          e.rate_z        = gyr[2] - gyr_off_m[2];
          e.offsets_ready = calibrated_m;
          tilt_results_q.push_back(e);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (tilt_results_q.size() == 0) begin
          $error("result beat with no measurement outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          r = tilt_results_q.pop_front();
          if (roll_i !== r.roll || pitch_i !== r.pitch || rate_x_i !== r.rate_x ||
              rate_y_i !== r.rate_y || rate_z_i !== r.rate_z ||
              offsets_ready_i !== r.offsets_ready)
            fail_count_o <= fail_count_o + 1;
          if (roll_i !== r.roll)
            $error("roll: expected %0d, got %0d", r.roll, roll_i);
          if (pitch_i !== r.pitch)
            $error("pitch: expected %0d, got %0d", r.pitch, pitch_i);
          if (rate_x_i !== r.rate_x)
            $error("rate_x: expected %0d, got %0d", r.rate_x, rate_x_i);
          if (rate_y_i !== r.rate_y)
            $error("rate_y: expected %0d, got %0d", r.rate_y, rate_y_i);
          if (rate_z_i !== r.rate_z)
            $error("rate_z: expected %0d, got %0d", r.rate_z, rate_z_i);
          if (offsets_ready_i !== r.offsets_ready)
            $error("offsets_ready: expected %0d, got %0d", r.offsets_ready, offsets_ready_i);
        end
      end
    end
  end

endmodule

/* tb/tb_accel_tilt_with_bias_calibration.sv */
// Top of the tilt block testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_accel_tilt_with_bias_calibration;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 3000;
  localparam int LongHold   = 400;
  localparam int Settle     = 100;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic               out_valid;
  logic               out_ready;
  logic signed [14:0] roll, pitch;
  logic signed [15:0] rate_x, rate_y, rate_z;
  logic               offsets_ready;
  int                 fail_count;
  int                 pending;

  bit idle_on;
  bit long_hold;
  int samples_sent;
  int cal_sets;

  accel_tilt_with_bias_calibration DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .kind_i(kind),
    .accel_x_i(ax), .accel_y_i(ay), .accel_z_i(az),
    .gyro_x_i(gx), .gyro_y_i(gy), .gyro_z_i(gz),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .roll_o(roll), .pitch_o(pitch), .rate_x_o(rate_x), .rate_y_o(rate_y),
    .rate_z_o(rate_z), .offsets_ready_o(offsets_ready)
  );

  tilt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .kind_i(kind),
    .accel_x_i(ax), .accel_y_i(ay), .accel_z_i(az),
    .gyro_x_i(gx), .gyro_y_i(gy), .gyro_z_i(gz),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .roll_i(roll), .pitch_i(pitch), .rate_x_i(rate_x), .rate_y_i(rate_y),
    .rate_z_i(rate_z), .offsets_ready_i(offsets_ready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Random 16-bit count: full range, extremes, or small values around a base.
  function automatic logic signed [15:0] pick_count(input int base);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'(base + $signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Offers one sample beat and waits until it is accepted.
  task automatic send_sample(input logic k, input logic signed [15:0] vax, vay, vaz,
                             input logic signed [15:0] vgx, vgy, vgz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    ax <= vax; ay <= vay; az <= vaz;
    gx <= vgx; gy <= vgy; gz <= vgz;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  // Waits for all results and for the block to go quiet, then writes the range.
  task automatic set_range(input logic [1:0] r);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One calibration set around a resting attitude; the range may change midway.
  task automatic calibrate(input int bx, by, bz, input int change_at, input logic [1:0] r2);
    for (int i = 0; i < tlt_pkg::CalSamples; i++) begin
      if (i == change_at) set_range(r2);
      send_sample(1'b0, pick_count(bx), pick_count(by), pick_count(bz),
                  pick_count(0), pick_count(0), pick_count(0));
    end
    cal_sets++;
  endtask

  task automatic measure(input int n, input int bz);
    for (int i = 0; i < n; i++)
      send_sample(1'b1, pick_count(0), pick_count(0), pick_count(bz),
                  pick_count(0), pick_count(0), pick_count(0));
  endtask

  // Stimulus and verdict.
  initial begin
    cfg_we = 1'b0; cfg_data = '0; in_valid = 1'b0; kind = 1'b0;
    ax = '0; ay = '0; az = '0; gx = '0; gy = '0; gz = '0;
    idle_on = 1'b1; long_hold = 1'b0; samples_sent = 0; cal_sets = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: measurements before any calibration, field extremes, zero operands.
    send_sample(1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(1'b1, 16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8000);
    send_sample(1'b1, 16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh0000, 16'shc000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(1'b1, 16'sh0001, 16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa, 16'sh1234);

    // Calibrations at each range, two with a range change partway through.
    calibrate(0, 0, 16384, -1, 2'd0);
    measure(80, 16384);
    set_range(2'd3);
    calibrate(300, -200, 2048, -1, 2'd3);
    measure(60, 2048);
    // Long receiver hold-off while measurements keep coming.
    long_hold = 1'b1;
    measure(60, 2048);
    set_range(2'd1);
    calibrate(-500, 800, 8192, 40, 2'd2);
    measure(80, 4096);
    calibrate(-30000, 30000, -30000, -1, 2'd2);
    measure(80, 0);
    set_range(2'd0);
    calibrate(100, 100, 16000, 70, 2'd1);
    measure(60, 8192);
    // Last stretch runs with no idling on either side.
    set_range(2'd2);
    idle_on = 1'b0;
    calibrate(0, 0, 4096, -1, 2'd2);
    measure(40, 4096);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);

    $display("Sent %0d sample beats, %0d calibration sets, all four ranges.",
             samples_sent, cal_sets);
    $display("Mismatches: %0d, results still outstanding: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
